### src/nearest_ray_segment_hit_unit_macros.svh
// assertion macros for the nearest ray segment hit unit
// included by the top level, no other dependencies
`ifndef NEAREST_RAY_SEGMENT_HIT_UNIT_MACROS_SVH
`define NEAREST_RAY_SEGMENT_HIT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NRSH_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("nrsh implication check failed");
`define NRSH_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("nrsh next cycle check failed");
`else
`define NRSH_ASSERT_IMP(label, clk, rst_n, a, b)
`define NRSH_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

### src/nrsh_pkg.sv
// shared widths, controller states and command/status structs
// no dependencies
`default_nettype none
package nrsh_pkg;
    localparam int COORD_W       = 20;
    localparam int DIR_W         = 16;
    localparam int DIST_W        = 41;
    localparam int IDX_W         = 5;
    localparam int CNT_W         = 6;
    localparam int PADDR_W       = 3;
    localparam int MAX_WALLS_DEF = 32;
    localparam int QW            = 21;
    localparam int DW            = 38;
    localparam int MW            = 59;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_SUB, S_MUL, S_SUM, S_CHECK, S_PMUL,
        S_DIVI, S_DIV, S_SQ, S_CMP, S_NEXT, S_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic mem_we;
        logic mem_re;
        logic sub_en;
        logic mul_en;
        logic sum_en;
        logic pmul_en;
        logic div_init;
        logic div_step;
        logic sq_en;
        logic cmp_en;
        logic idx_inc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic last;
        logic wall_ok;
        logic div_last;
        logic out_busy;
    } status_t;
endpackage
`default_nettype wire

### src/nrsh_ctrl.sv
// controller state machine for wall loads and for the wall walk of one cast
// depends on nrsh_pkg
`default_nettype none
module nrsh_ctrl import nrsh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    action,
    input  wire status_t status,
    output logic         in_stall,
    output cmd_t         cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action && !status.n_zero)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_READ:  state_next = S_SUB;
            S_SUB:   state_next = S_MUL;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_CHECK;
            S_CHECK: state_next = status.wall_ok ? S_PMUL : S_NEXT;
            S_PMUL:  state_next = S_DIVI;
            S_DIVI:  state_next = S_DIV;
            S_DIV:   state_next = status.div_last ? S_SQ : S_DIV;
            S_SQ:    state_next = S_CMP;
            S_CMP:   state_next = S_NEXT;
            S_NEXT:  state_next = status.last ? S_FIN : S_READ;
            S_FIN:   state_next = status.out_busy ? S_FIN : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.start    = in_valid;
                cmd.mem_we   = in_valid && !action;
            end
            S_READ:  cmd.mem_re   = 1'b1;
            S_SUB:   cmd.sub_en   = 1'b1;
            S_MUL:   cmd.mul_en   = 1'b1;
            S_SUM:   cmd.sum_en   = 1'b1;
            S_PMUL:  cmd.pmul_en  = 1'b1;
            S_DIVI:  cmd.div_init = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_SQ:    cmd.sq_en    = 1'b1;
            S_CMP:   cmd.cmp_en   = 1'b1;
            S_NEXT:  cmd.idx_inc  = 1'b1;
            S_FIN:   cmd.out_load = !status.out_busy;
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

### src/nrsh_div.sv
// restoring divider, one quotient bit per cycle while step is high, rounds to nearest
// depends on nrsh_pkg
`default_nettype none
module nrsh_div import nrsh_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          init,
    input  wire logic          step,
    input  wire logic [MW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo,
    output logic               ovf
);
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] lo_reg;
    logic [QW-1:0] quo_reg;
    logic          ovf_reg;
    logic [MW:0]   biased;
    logic [DW:0]   trial;
    logic          ge;

    // bias by half the divisor for rounding
    assign biased = {1'b0, num} + {{(MW-DW+2){1'b0}}, den[DW-1:1]};
    assign trial  = {rem_reg, lo_reg[QW-1]};
    assign ge     = trial >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            den_reg <= den;
            ovf_reg <= biased[MW:QW] >= {{(MW-QW+1-DW){1'b0}}, den};
            rem_reg <= biased[DW+QW-1:QW];
            lo_reg  <= biased[QW-1:0];
            quo_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            lo_reg  <= {lo_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;
endmodule
`default_nettype wire

### src/nrsh_datapath.sv
// wall table, intersection arithmetic, nearest tracking and result register
// depends on nrsh_pkg and nrsh_div
`default_nettype none
module nrsh_datapath import nrsh_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output status_t                        status,
    input  wire logic [CNT_W-1:0]          wall_count,
    input  wire logic [IDX_W-1:0]          wall_index,
    input  wire logic signed [COORD_W-1:0] start_x,
    input  wire logic signed [COORD_W-1:0] start_y,
    input  wire logic signed [COORD_W-1:0] end_x,
    input  wire logic signed [COORD_W-1:0] end_y,
    input  wire logic signed [COORD_W-1:0] origin_x,
    input  wire logic signed [COORD_W-1:0] origin_y,
    input  wire logic signed [DIR_W-1:0]   dir_x,
    input  wire logic signed [DIR_W-1:0]   dir_y,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic                           hit,
    output logic signed [COORD_W-1:0]      hit_x,
    output logic signed [COORD_W-1:0]      hit_y,
    output logic        [DIST_W-1:0]       dist_sq
);
    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW = $clog2(MAX_WALLS + 1);
    localparam int EW = 4 * COORD_W;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W+2:0] v);
        logic signed [COORD_W+2:0] hi;
        logic signed [COORD_W+2:0] lo;
        hi = (COORD_W+3)'(2 ** (COORD_W-1) - 1);
        lo = -(COORD_W+3)'(2 ** (COORD_W-1));
        if (v > hi)
            return {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return v[COORD_W-1:0];
    endfunction

    logic [CW-1:0] idx_reg;

    // wall table: {end_y, end_x, start_y, start_x}
    logic [EW-1:0] wall_mem [MAX_WALLS];
    logic [EW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we && (32'(wall_index) < MAX_WALLS))
        begin
            wall_mem[AW'(wall_index)] <= {end_y, end_x, start_y, start_x};
        end
        if (cmd.mem_re)
        begin
            rd_reg <= wall_mem[idx_reg[AW-1:0]];
        end
    end

    logic [CW-1:0] n_eff;
    logic [CW:0]   idx_plus;

    assign n_eff    = (32'(wall_count) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(wall_count);
    assign idx_plus = {1'b0, idx_reg} + 1'b1;

    logic signed [COORD_W-1:0] ox_reg, oy_reg;
    logic signed [DIR_W-1:0]   dx_reg, dy_reg;
    logic signed [COORD_W:0]   wx_reg, wy_reg, rx_reg, ry_reg;
    logic signed [DIR_W+COORD_W:0]   p_dywx_reg, p_dxwy_reg, p_rydx_reg, p_rxdy_reg;
    logic signed [2*COORD_W+1:0]     p_rxwy_reg, p_rywx_reg;
    logic signed [DW-1:0]            den_reg, un_reg;
    logic signed [2*COORD_W+2:0]     tn_reg;
    logic signed [MW-1:0]            px_reg, py_reg;
    logic                            negx_reg, negy_reg;
    logic [4:0]                      div_cnt_reg;

    logic signed [DW-1:0]        den_s, un_s;
    logic signed [2*COORD_W+2:0] tn_s;

    assign den_s = DW'(p_dywx_reg) - DW'(p_dxwy_reg);
    assign un_s  = DW'(p_rydx_reg) - DW'(p_rxdy_reg);
    assign tn_s  = (2*COORD_W+3)'(p_rxwy_reg) - (2*COORD_W+3)'(p_rywx_reg);

    logic [MW-1:0] magx, magy;
    logic [QW-1:0] qx, qy;
    logic          ovfx, ovfy;

    assign magx = px_reg[MW-1] ? MW'(-px_reg) : MW'(px_reg);
    assign magy = py_reg[MW-1] ? MW'(-py_reg) : MW'(py_reg);

    nrsh_div u_div_x
    (
        .clk  (clk),
        .init (cmd.div_init),
        .step (cmd.div_step),
        .num  (magx),
        .den  (den_reg),
        .quo  (qx),
        .ovf  (ovfx)
    );

    nrsh_div u_div_y
    (
        .clk  (clk),
        .init (cmd.div_init),
        .step (cmd.div_step),
        .num  (magy),
        .den  (den_reg),
        .quo  (qy),
        .ovf  (ovfy)
    );

    logic signed [COORD_W+2:0] sum_x, sum_y;
    assign sum_x = (COORD_W+3)'(ox_reg) + (negx_reg ? -(COORD_W+3)'({1'b0, qx})
                                                    :  (COORD_W+3)'({1'b0, qx}));
    assign sum_y = (COORD_W+3)'(oy_reg) + (negy_reg ? -(COORD_W+3)'({1'b0, qy})
                                                    :  (COORD_W+3)'({1'b0, qy}));

    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic [2*QW-1:0]           sqx_reg, sqy_reg;
    logic                      sovf_reg;
    logic [2*QW:0]             sq_sum;
    logic [DIST_W-1:0]         d_cand;

    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign d_cand = (sovf_reg || (sq_sum > {2'b0, DIST_MAX})) ? DIST_MAX
                                                              : sq_sum[DIST_W-1:0];

    logic                      found_reg;
    logic signed [COORD_W-1:0] bx_reg, by_reg;
    logic [DIST_W-1:0]         bd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ox_reg <= origin_x;
            oy_reg <= origin_y;
            dx_reg <= dir_x;
            dy_reg <= dir_y;
        end
        if (cmd.sub_en)
        begin
            wx_reg <= (COORD_W+1)'($signed(rd_reg[COORD_W-1:0]))
                    - (COORD_W+1)'($signed(rd_reg[3*COORD_W-1:2*COORD_W]));
            wy_reg <= (COORD_W+1)'($signed(rd_reg[2*COORD_W-1:COORD_W]))
                    - (COORD_W+1)'($signed(rd_reg[4*COORD_W-1:3*COORD_W]));
            rx_reg <= (COORD_W+1)'(ox_reg) - (COORD_W+1)'($signed(rd_reg[COORD_W-1:0]));
            ry_reg <= (COORD_W+1)'(oy_reg)
                    - (COORD_W+1)'($signed(rd_reg[2*COORD_W-1:COORD_W]));
        end
        if (cmd.mul_en)
        begin
            p_dywx_reg <= dy_reg * wx_reg;
            p_dxwy_reg <= dx_reg * wy_reg;
            p_rydx_reg <= ry_reg * dx_reg;
            p_rxdy_reg <= rx_reg * dy_reg;
            p_rxwy_reg <= rx_reg * wy_reg;
            p_rywx_reg <= ry_reg * wx_reg;
        end
        if (cmd.sum_en)
        begin
            // normalize so the denominator is positive
            den_reg <= den_s[DW-1] ? -den_s : den_s;
            un_reg  <= den_s[DW-1] ? -un_s  : un_s;
            tn_reg  <= den_s[DW-1] ? -tn_s  : tn_s;
        end
        if (cmd.pmul_en)
        begin
            px_reg <= tn_reg * dx_reg;
            py_reg <= tn_reg * dy_reg;
        end
        if (cmd.div_init)
        begin
            negx_reg <= px_reg[MW-1];
            negy_reg <= py_reg[MW-1];
        end
        if (cmd.sq_en)
        begin
            cx_reg   <= ovfx ? (negx_reg ? {1'b1, {(COORD_W-1){1'b0}}}
                                         : {1'b0, {(COORD_W-1){1'b1}}})
                             : sat_coord(sum_x);
            cy_reg   <= ovfy ? (negy_reg ? {1'b1, {(COORD_W-1){1'b0}}}
                                         : {1'b0, {(COORD_W-1){1'b1}}})
                             : sat_coord(sum_y);
            sqx_reg  <= qx * qx;
            sqy_reg  <= qy * qy;
            sovf_reg <= ovfx || ovfy;
        end
        if (cmd.cmp_en && (!found_reg || (d_cand < bd_reg)))
        begin
            bx_reg <= cx_reg;
            by_reg <= cy_reg;
            bd_reg <= d_cand;
        end
        if (cmd.out_load)
        begin
            hit     <= found_reg;
            hit_x   <= found_reg ? bx_reg : '0;
            hit_y   <= found_reg ? by_reg : '0;
            dist_sq <= found_reg ? bd_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            div_cnt_reg <= '0;
            found_reg   <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus[CW-1:0];
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.cmp_en)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    assign status.n_zero   = (n_eff == '0);
    assign status.last     = (idx_plus == {1'b0, n_eff});
    assign status.wall_ok  = (den_reg != '0) && !tn_reg[2*COORD_W+2] && !un_reg[DW-1]
                             && (un_reg <= den_reg);
    assign status.div_last = (div_cnt_reg == 5'(QW - 1));
    assign status.out_busy = out_valid && out_stall;
endmodule
`default_nettype wire

### src/nearest_ray_segment_hit_unit.sv
// load item: written to the wall table at transfer, result loaded in S_FIN; cast: a rejected wall
// ends after S_CHECK, a hit wall also runs a serial 21-step divider; one item in flight at a time
// a finished result waits in the output register while the next item is taken
// reset: wall_count clears to 0, controller idles, wall table stays undefined
// top level: apb register, controller and datapath
// depends on nrsh_pkg, nrsh_ctrl, nrsh_datapath and the macros header
`default_nettype none
`include "nearest_ray_segment_hit_unit_macros.svh"
module nearest_ray_segment_hit_unit import nrsh_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // apb configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      action,
    input  wire logic [IDX_W-1:0]          wall_index,
    input  wire logic signed [COORD_W-1:0] start_x,
    input  wire logic signed [COORD_W-1:0] start_y,
    input  wire logic signed [COORD_W-1:0] end_x,
    input  wire logic signed [COORD_W-1:0] end_y,
    input  wire logic signed [COORD_W-1:0] origin_x,
    input  wire logic signed [COORD_W-1:0] origin_y,
    input  wire logic signed [DIR_W-1:0]   dir_x,
    input  wire logic signed [DIR_W-1:0]   dir_y,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           hit,
    output logic signed [COORD_W-1:0]      hit_x,
    output logic signed [COORD_W-1:0]      hit_y,
    output logic        [DIST_W-1:0]       dist_sq
);
    // wall_count sits at byte address 0; only paddr[2] is decoded, so addresses 0 to 3 all select it
    logic [CNT_W-1:0] wall_count_reg;
    logic             sel_count;

    assign sel_count = (paddr[PADDR_W-1] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = sel_count ? {{(32-CNT_W){1'b0}}, wall_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_count_reg <= '0;
        end
        else if (psel && penable && pwrite && sel_count)
        begin
            wall_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // commands down to the datapath, status back to the controller
    cmd_t    cmd;
    status_t status;

    nrsh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    nrsh_datapath #(
        .MAX_WALLS (MAX_WALLS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .wall_count (wall_count_reg),
        .wall_index (wall_index),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .hit        (hit),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .dist_sq    (dist_sq)
    );

    // an accepted item always keeps the block busy for the next cycle
    `NRSH_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)
    // a miss or a load reports all zero payload
    `NRSH_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !hit,
        hit_x == '0 && hit_y == '0 && dist_sq == '0)
    // a new result only appears out of a busy cycle
    `NRSH_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))
endmodule
`default_nettype wire
